// ===== sv/nmss_pkg.sv =====
// Package for the Nelder-Mead simplex stepper: sizes, fixed-point constants,
// phase and sequencer state types, and the saturation helper.
// Depends on nothing; the top level imports it.
`default_nettype none
package nmss_pkg;
	localparam int MAX_DIMS  = 8;
	localparam int FRAC_BITS = 16;
	localparam int VTX_N     = MAX_DIMS + 1;
	localparam int CI_W      = $clog2(MAX_DIMS);
	localparam int VI_W      = $clog2(VTX_N);
	localparam int D_W       = $clog2(MAX_DIMS + 1);
	localparam int AW        = VI_W + CI_W;
	localparam int RAM_DEPTH = VTX_N * (1 << CI_W);
	localparam int SUM_W     = 32 + VI_W;
	localparam int MAG_W     = SUM_W - 1;
	localparam int CNT_W     = $clog2(MAG_W + 1);
	localparam int DIMS_W    = 4;
	localparam int STEP_W    = 16;

	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam longint Q_DX  = (Q_ONE * 2 + 50) / 100;
	localparam logic signed [FRAC_BITS+2:0] SCALE_C = (FRAC_BITS+3)'(Q_ONE + Q_DX);
	localparam logic signed [FRAC_BITS+2:0] HALF_C  = (FRAC_BITS+3)'(Q_ONE >> 1);
	localparam int PROD_W = 32 + FRAC_BITS + 3;

	localparam logic REG_DIMS = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	typedef enum logic [2:0] {
		PH_BUILD, PH_READY, PH_REFLECTED, PH_EXPANDED, PH_CONTRACTED, PH_SHRINK
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_COPY, S_BLD_WR, S_BLD_CHK, S_BLD_RD, S_BLD_USE,
		S_SHR0, S_SHR_RDL, S_SHR_RDI, S_SHR_WR, S_ORD_INIT, S_ORD_LOOP,
		S_CEN_RD, S_CEN_ACC, S_DIV, S_DIV_FIN, S_CTR_RD, S_CTR_USE, S_FIN, S_EMIT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > PROD_W'(32'sh7fffffff)) r = 32'sh7fffffff;
		else if (v < -PROD_W'(64'sh80000000)) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/nelder_mead_simplex_stepper_unit.sv =====
// Top level of the Nelder-Mead simplex stepper: sequencer, small state arrays
// and the vertex coordinate memory. Depends on nmss_pkg and nmss_ram.
//
// Usage: send the coordinates of the evaluated point one per transaction on
// start/coord_value; the transaction with coord_last high also carries
// cost_value and starts one optimizer step. A transaction is taken at a
// rising edge with start high and busy low. Coordinate transactions without
// coord_last never raise busy.
// The step produces dims_in_use results, one per cycle, each marked by a
// one-cycle next_valid pulse; next_last marks the last, done_res repeats the
// step-limit flag. The receiver cannot stall, so each result must be taken in
// the cycle it is shown.
// All vertex coordinates sit in one memory with one read per cycle.
// Ordering and the centroid dominate the step time.
// Reflection-only steps that go straight to ordering cost the same;
// expansion steps skip both. Configuration writes are taken any time
// the block is idle. Reset clears the sequencer and the optimizer phase;
// no clearing pass is needed.
`default_nettype none
module nelder_mead_simplex_stepper_unit
	import nmss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [STEP_W-1:0]     cfg_data,
	input  wire logic signed [31:0]    coord_value,
	input  wire logic                  coord_last,
	input  wire logic signed [31:0]    cost_value,
	output logic                       next_valid,
	output logic signed [31:0]         next_coord,
	output logic                       next_last,
	output logic                       done_res
);
	state_t state_q, state_d;
	phase_t ph_q;

	logic [DIMS_W-1:0] dims_q;
	logic [STEP_W-1:0] max_q, step_q;
	logic [CI_W-1:0]   ci_q, j_q;
	logic [VI_W-1:0]   i_q, h_q, l_q, g_q, vc_q, si_q;
	logic              sh_busy_q, done_q, src_refl_q;
	state_t            ret_q;

	logic signed [31:0] inc_q [MAX_DIMS];
	logic signed [31:0] cen_q [MAX_DIMS];
	logic signed [31:0] refl_q [MAX_DIMS];
	logic signed [31:0] pt_q [MAX_DIMS];
	logic signed [31:0] costs_q [VTX_N];
	logic signed [31:0] cost_q, rcost_q, xl_q, xh_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [D_W-1:0]     rem_q;
	logic [CNT_W-1:0]   dcnt_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic signed [31:0]  ram_wdata, ram_rdata;

	logic [D_W-1:0]      d;
	logic [D_W-1:0]      idx;
	logic                accept, j_last;
	logic                lt_w, lt_b, lt_sw;
	logic [VI_W-1:0]     h1, g1, l1, si_n;
	logic signed [SUM_W-1:0] acc;
	logic [D_W:0]        r2;
	logic signed [MAG_W:0]   qs;
	logic signed [31:0]  cval, bld_val, shr_val;
	logic signed [32:0]  diff, half, ctr_sum;
	logic signed [PROD_W-1:0] prod;

	nmss_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_vtx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (dims_q == '0) d = D_W'(1);
		else if (D_W'(dims_q) > D_W'(MAX_DIMS)) d = D_W'(MAX_DIMS);
		else d = D_W'(dims_q);
		idx    = (D_W'(ci_q) < d) ? D_W'(ci_q) : d - 1'b1;
		busy   = (state_q != S_IDLE);
		accept = start && !busy;
		j_last = (D_W'(j_q) == d - 1'b1);
		lt_w   = cost_q < costs_q[h_q];
		lt_b   = cost_q < costs_q[l_q];
		lt_sw  = cost_q < costs_q[g_q];

		h1 = h_q;
		g1 = g_q;
		if (costs_q[h_q] < costs_q[i_q]) begin
			if (costs_q[g_q] < costs_q[h_q] || g_q == i_q) g1 = h_q;
			h1 = i_q;
		end
		l1 = (costs_q[l_q] > costs_q[i_q]) ? i_q : l_q;
		if (costs_q[g1] < costs_q[i_q] && h1 != i_q) g1 = i_q;

		si_n = sh_busy_q ? si_q + 1'b1 : '0;
		if (si_n == l_q) si_n = si_n + 1'b1;

		acc  = sum_q + ((i_q != h_q) ? SUM_W'(ram_rdata) : '0);
		r2   = {rem_q, mag_q[MAG_W-1]};
		qs   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		cval = qs[31:0];

		prod    = ram_rdata * SCALE_C + HALF_C;
		bld_val = (D_W'(j_q) == D_W'(vc_q) - 1'b1) ?
			sat32(prod >>> FRAC_BITS) : ram_rdata;
		diff    = 33'(ram_rdata) - 33'(xl_q);
		half    = diff >>> 1;
		shr_val = 32'(33'(xl_q) + half);
		ctr_sum = 33'(cen_q[j_q]) + 33'(ram_rdata);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && coord_last) state_d = S_DECIDE;
			S_DECIDE: begin
				unique case (ph_q)
					PH_CONTRACTED: state_d = lt_w ? S_COPY : S_SHR0;
					PH_EXPANDED: state_d = S_COPY;
					PH_REFLECTED: begin
						if (lt_b) state_d = S_FIN;
						else if (lt_sw || lt_w) state_d = S_COPY;
						else state_d = S_CTR_RD;
					end
					PH_BUILD: state_d = (vc_q <= VI_W'(MAX_DIMS)) ? S_BLD_WR : S_BLD_CHK;
					PH_SHRINK: state_d = S_SHR0;
					default: state_d = S_ORD_INIT;
				endcase
			end
			S_COPY: if (j_last) state_d = ret_q;
			S_BLD_WR: if (j_last) state_d = S_BLD_CHK;
			S_BLD_CHK: state_d = (D_W'(vc_q) - 1'b1 < d) ? S_BLD_RD : S_ORD_INIT;
			S_BLD_RD: state_d = S_BLD_USE;
			S_BLD_USE: state_d = j_last ? S_FIN : S_BLD_RD;
			S_SHR0: state_d = (D_W'(si_n) > d) ? S_ORD_INIT : S_SHR_RDL;
			S_SHR_RDL: state_d = S_SHR_RDI;
			S_SHR_RDI: state_d = S_SHR_WR;
			S_SHR_WR: state_d = j_last ? S_FIN : S_SHR_RDL;
			S_ORD_INIT: state_d = S_ORD_LOOP;
			S_ORD_LOOP: if (D_W'(i_q) == d) state_d = S_CEN_RD;
			S_CEN_RD: state_d = S_CEN_ACC;
			S_CEN_ACC: state_d = (D_W'(i_q) == d) ? S_DIV : S_CEN_RD;
			S_DIV: if (dcnt_q == CNT_W'(MAG_W - 1)) state_d = S_DIV_FIN;
			S_DIV_FIN: state_d = j_last ? S_FIN : S_CEN_RD;
			S_CTR_RD: state_d = S_CTR_USE;
			S_CTR_USE: state_d = j_last ? S_FIN : S_CTR_RD;
			S_FIN: state_d = S_EMIT;
			S_EMIT: if (j_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {h_q, j_q};
		ram_wdata = src_refl_q ? refl_q[j_q] : inc_q[j_q];
		ram_raddr = {i_q, j_q};
		unique case (state_q)
			S_COPY: ram_we = 1'b1;
			S_BLD_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {vc_q, j_q};
				ram_wdata = inc_q[j_q];
			end
			S_SHR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {si_q, j_q};
				ram_wdata = shr_val;
			end
			S_BLD_RD: ram_raddr = {VI_W'(0), j_q};
			S_SHR_RDL: ram_raddr = {l_q, j_q};
			S_SHR_RDI: ram_raddr = {si_q, j_q};
			S_CTR_RD: ram_raddr = {h_q, j_q};
			default: ram_raddr = {i_q, j_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ph_q       <= PH_BUILD;
			dims_q     <= DIMS_W'(2);
			max_q      <= STEP_W'(1000);
			step_q     <= '0;
			ci_q       <= '0;
			j_q        <= '0;
			i_q        <= '0;
			h_q        <= '0;
			l_q        <= '0;
			g_q        <= VI_W'(1);
			vc_q       <= '0;
			si_q       <= '0;
			sh_busy_q  <= 1'b0;
			done_q     <= 1'b0;
			src_refl_q <= 1'b0;
			ret_q      <= S_ORD_INIT;
			rcost_q    <= '0;
			next_valid <= 1'b0;
		end else begin
			state_q    <= state_d;
			next_valid <= (state_q == S_EMIT);
			if (cfg_we) begin
				if (cfg_index == REG_DIMS) dims_q <= cfg_data[DIMS_W-1:0];
				else if (cfg_index == REG_MAX) max_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						inc_q[idx[CI_W-1:0]] <= coord_value;
						cost_q <= cost_value;
						if (coord_last) ci_q <= '0;
						else ci_q <= (idx + 1'b1 < d) ? CI_W'(idx + 1'b1) : CI_W'(d - 1'b1);
					end
					j_q <= '0;
				end
				S_DECIDE: begin
					unique case (ph_q)
						PH_CONTRACTED: begin
							src_refl_q <= 1'b0;
							ret_q      <= S_ORD_INIT;
							if (lt_w) costs_q[h_q] <= cost_q;
							else ph_q <= PH_SHRINK;
						end
						PH_EXPANDED: begin
							ret_q      <= S_ORD_INIT;
							src_refl_q <= !lt_b;
							if (lt_b) costs_q[h_q] <= cost_q;
							else costs_q[h_q] <= rcost_q;
						end
						PH_REFLECTED: begin
							src_refl_q <= 1'b0;
							for (int k = 0; k < MAX_DIMS; k++) begin
								if (k < int'(d)) refl_q[k] <= inc_q[k];
							end
							rcost_q <= cost_q;
							if (lt_b) begin
								ret_q <= S_ORD_INIT;
								for (int k = 0; k < MAX_DIMS; k++) begin
									pt_q[k] <= sat32(PROD_W'(inc_q[k]) * 2 - PROD_W'(cen_q[k]));
								end
								ph_q <= PH_EXPANDED;
							end else if (lt_sw) begin
								ret_q <= S_ORD_INIT;
								costs_q[h_q] <= cost_q;
							end else begin
								if (lt_w) costs_q[h_q] <= cost_q;
								ret_q <= S_CTR_RD;
								ph_q  <= PH_CONTRACTED;
							end
						end
						PH_BUILD: begin
							if (vc_q <= VI_W'(MAX_DIMS)) costs_q[vc_q] <= cost_q;
						end
						default: ;
					endcase
				end
				S_COPY: j_q <= j_last ? '0 : j_q + 1'b1;
				S_BLD_WR: begin
					j_q <= j_last ? '0 : j_q + 1'b1;
					if (j_last) vc_q <= vc_q + 1'b1;
				end
				S_BLD_CHK: begin
					j_q <= '0;
					if (!(D_W'(vc_q) - 1'b1 < d)) ph_q <= PH_READY;
				end
				S_BLD_USE: begin
					pt_q[j_q] <= bld_val;
					j_q <= j_q + 1'b1;
				end
				S_SHR0: begin
					j_q <= '0;
					if (sh_busy_q) costs_q[si_q] <= cost_q;
					if (D_W'(si_n) > d) begin
						sh_busy_q <= 1'b0;
						si_q      <= '0;
						ph_q      <= PH_READY;
					end else begin
						sh_busy_q <= 1'b1;
						si_q      <= si_n;
					end
				end
				S_SHR_RDI: xl_q <= ram_rdata;
				S_SHR_WR: begin
					pt_q[j_q] <= shr_val;
					j_q <= j_q + 1'b1;
				end
				S_ORD_INIT: begin
					h_q <= '0;
					l_q <= '0;
					g_q <= VI_W'(1);
					i_q <= VI_W'(1);
				end
				S_ORD_LOOP: begin
					h_q <= h1;
					l_q <= l1;
					g_q <= g1;
					if (D_W'(i_q) == d) begin
						i_q   <= '0;
						j_q   <= '0;
						sum_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_CEN_ACC: begin
					sum_q <= acc;
					if (i_q == h_q) xh_q <= ram_rdata;
					i_q <= i_q + 1'b1;
					if (D_W'(i_q) == d) begin
						neg_q  <= acc[SUM_W-1];
						mag_q  <= acc[SUM_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
						rem_q  <= '0;
						dcnt_q <= '0;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (r2 >= {1'b0, d}) begin
						rem_q <= D_W'(r2 - {1'b0, d});
						mag_q <= {mag_q[MAG_W-2:0], 1'b1};
					end else begin
						rem_q <= r2[D_W-1:0];
						mag_q <= {mag_q[MAG_W-2:0], 1'b0};
					end
				end
				S_DIV_FIN: begin
					cen_q[j_q]  <= cval;
					refl_q[j_q] <= sat32(PROD_W'(cval) * 2 - PROD_W'(xh_q));
					pt_q[j_q]   <= sat32(PROD_W'(cval) * 2 - PROD_W'(xh_q));
					i_q   <= '0;
					sum_q <= '0;
					j_q   <= j_q + 1'b1;
					if (j_last) ph_q <= PH_REFLECTED;
				end
				S_CTR_USE: begin
					pt_q[j_q] <= ctr_sum[32:1];
					j_q <= j_q + 1'b1;
				end
				S_FIN: begin
					j_q <= '0;
					if (step_q >= max_q) done_q <= 1'b1;
					else begin
						done_q <= 1'b0;
						step_q <= step_q + 1'b1;
					end
				end
				S_EMIT: begin
					next_coord <= pt_q[j_q];
					next_last  <= j_last;
					done_res   <= done_q;
					j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/nmss_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module nmss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 72
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
